@@ sv/fsk_symbol_classify_and_sync_top_defines.svh @@
// assertion macros for the fsk symbol classify and sync block
`ifndef FSK_SYMBOL_CLASSIFY_AND_SYNC_TOP_DEFINES_SVH
`define FSK_SYMBOL_CLASSIFY_AND_SYNC_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define FSKSCS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FSKSCS_ASSERT_CLK(lbl, prop, msg) `FSKSCS_ASSERT(lbl, clk_i, rst_ni, prop, msg)
`else
`define FSKSCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define FSKSCS_ASSERT_CLK(lbl, prop, msg)
`endif
`endif

@@ sv/fskscs_pkg.sv @@
// shared types and constants of the fsk symbol classify and sync block
`default_nettype none
package fskscs_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 128;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned SIZE_W   = 8;
  localparam int unsigned TOL_W    = 7;
  localparam int unsigned DEV_W    = 9;
  localparam int unsigned HI_W     = 10;
  localparam int unsigned PROD_W   = 15;
  localparam int unsigned RECIP_W  = 13;
  localparam int unsigned XCNT_W   = 6;
  localparam int unsigned OFF_W    = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned STATUS_W = 2;

  // floor(x / 100) as (x * 5243) >> 19 for x below 2^15
  localparam logic [RECIP_W-1:0] RECIP_MUL = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;

  localparam logic [LEN_W-1:0] MAX_SYNC_LEN  = 7'd64;
  localparam logic [LEN_W-1:0] MAX_DATA_BITS = 7'd64;

  localparam logic [WORD_W-1:0] RST_SYNC_PATTERN = '0;
  localparam logic [LEN_W-1:0]  RST_SYNC_LENGTH  = 7'd0;
  localparam logic [LEN_W-1:0]  RST_DATA_BITS    = 7'd64;
  localparam logic              RST_REPEAT_TWICE = 1'b1;
  localparam logic              RST_INVERT       = 1'b0;
  localparam logic              RST_T0_ABOVE_T1  = 1'b0;
  localparam logic [TOL_W-1:0]  RST_TOLERANCE    = 7'd25;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_PATTERN,
    CFG_SYNC_LENGTH,
    CFG_DATA_BITS,
    CFG_REPEAT_TWICE,
    CFG_INVERT,
    CFG_T0_ABOVE_T1,
    CFG_TOLERANCE
  } cfg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_SIZES,
    ST_NO_SYNC,
    ST_COUNT
  } status_e;

  typedef struct packed {
    logic [WORD_W-1:0] sync_pattern;
    logic [LEN_W-1:0]  sync_length;
    logic [LEN_W-1:0]  data_bits;
    logic              repeat_twice;
    logic              invert;
    logic              t0_above_t1;
    logic [TOL_W-1:0]  tolerance_percent;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic clr_frame;
    logic clr_idx;
    logic inc_idx;
    logic rd_smp;
    logic tol_go;
    logic cap_b0;
    logic cap_b1;
    logic cls_step;
    logic ld_x;
    logic rd_bit;
    logic x_step;
    logic fin;
    logic fin_ok;
  } cmd_t;

  typedef struct packed {
    logic cfg_err;
    logic idx_last;
    logic near0;
    logic near1;
    logic have1;
    logic tol_done;
    logic found;
    logic sync_on;
    logic win_err;
    logic x_last;
  } sts_t;

endpackage
`default_nettype wire

@@ sv/fskscs_tol.sv @@
// two stage unit that turns a reference size into its allowed deviation
`default_nettype none
module fskscs_tol (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             go_i,
  input  wire logic [fskscs_pkg::SIZE_W-1:0]    size_i,
  input  wire logic [fskscs_pkg::TOL_W-1:0]     tol_i,
  output logic                                  done_o,
  output logic [fskscs_pkg::DEV_W-1:0]          dev_o
);

  localparam int unsigned MW = fskscs_pkg::PROD_W + fskscs_pkg::RECIP_W;

  logic                            s1_q;
  logic                            s2_q;
  logic [fskscs_pkg::PROD_W-1:0]   p_q;
  logic [fskscs_pkg::PROD_W-1:0]   p_d;
  logic [MW-1:0]                   prod;
  logic [fskscs_pkg::DEV_W-1:0]    dev_q;
  logic [fskscs_pkg::DEV_W-1:0]    dev_d;

  assign p_d   = fskscs_pkg::PROD_W'(size_i) * fskscs_pkg::PROD_W'(tol_i);
  assign prod  = MW'(p_q) * MW'(fskscs_pkg::RECIP_MUL);
  assign dev_d = fskscs_pkg::DEV_W'(prod >> fskscs_pkg::RECIP_SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      s1_q <= go_i;
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      p_q <= p_d;
    end
    if (s1_q) begin
      dev_q <= dev_d;
    end
  end

  assign done_o = s2_q;
  assign dev_o  = dev_q;

endmodule
`default_nettype wire

@@ sv/fskscs_ctrl.sv @@
// controller state machine that sequences loading, checking, classifying and packing
`default_nettype none
`include "fsk_symbol_classify_and_sync_top_defines.svh"
module fskscs_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire logic               last_sample_i,
  input  wire fskscs_pkg::sts_t   sts_i,
  output fskscs_pkg::cmd_t        cmd_o,
  output logic                    busy,
  output logic                    valid_o,
  output logic [fskscs_pkg::STATUS_W-1:0] status_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_REF0_RD,
    S_REF0_TOL,
    S_REF0_WAIT,
    S_P1_RD,
    S_P1_EV,
    S_REF1_WAIT,
    S_CLS_RD,
    S_CLS_EV,
    S_SYNC_CHK,
    S_X_RD,
    S_X_EV
  } state_e;

  state_e              state_q;
  state_e              state_d;
  logic                valid_q;
  logic                valid_d;
  fskscs_pkg::status_e status_q;
  fskscs_pkg::status_e status_d;
  fskscs_pkg::cmd_t    cmd;
  logic                fin;
  fskscs_pkg::status_e fin_code;

  always_comb begin
    state_d  = state_q;
    valid_d  = 1'b0;
    status_d = status_q;
    cmd      = '0;
    fin      = 1'b0;
    fin_code = fskscs_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_sample_i) begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts_i.cfg_err) begin
          fin      = 1'b1;
          fin_code = fskscs_pkg::ST_COUNT;
        end else begin
          cmd.clr_frame = 1'b1;
          cmd.clr_idx   = 1'b1;
          state_d       = S_REF0_RD;
        end
      end
      S_REF0_RD: begin
        cmd.rd_smp = 1'b1;
        state_d    = S_REF0_TOL;
      end
      S_REF0_TOL: begin
        cmd.tol_go = 1'b1;
        state_d    = S_REF0_WAIT;
      end
      S_REF0_WAIT: begin
        if (sts_i.tol_done) begin
          cmd.cap_b0 = 1'b1;
          if (sts_i.idx_last) begin
            cmd.clr_idx = 1'b1;
            state_d     = S_CLS_RD;
          end else begin
            cmd.inc_idx = 1'b1;
            state_d     = S_P1_RD;
          end
        end
      end
      S_P1_RD: begin
        cmd.rd_smp = 1'b1;
        state_d    = S_P1_EV;
      end
      S_P1_EV: begin
        if (!sts_i.have1 && !sts_i.near0) begin
          cmd.tol_go = 1'b1;
          state_d    = S_REF1_WAIT;
        end else if (!sts_i.near0 && !sts_i.near1) begin
          fin      = 1'b1;
          fin_code = fskscs_pkg::ST_SIZES;
        end else if (sts_i.idx_last) begin
          cmd.clr_idx = 1'b1;
          state_d     = S_CLS_RD;
        end else begin
          cmd.inc_idx = 1'b1;
          state_d     = S_P1_RD;
        end
      end
      S_REF1_WAIT: begin
        if (sts_i.tol_done) begin
          cmd.cap_b1 = 1'b1;
          if (sts_i.idx_last) begin
            cmd.clr_idx = 1'b1;
            state_d     = S_CLS_RD;
          end else begin
            cmd.inc_idx = 1'b1;
            state_d     = S_P1_RD;
          end
        end
      end
      S_CLS_RD: begin
        cmd.rd_smp = 1'b1;
        state_d    = S_CLS_EV;
      end
      S_CLS_EV: begin
        cmd.cls_step = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_SYNC_CHK;
        end else begin
          cmd.inc_idx = 1'b1;
          state_d     = S_CLS_RD;
        end
      end
      S_SYNC_CHK: begin
        if (sts_i.sync_on && !sts_i.found) begin
          fin      = 1'b1;
          fin_code = fskscs_pkg::ST_NO_SYNC;
        end else if (sts_i.win_err) begin
          fin      = 1'b1;
          fin_code = fskscs_pkg::ST_COUNT;
        end else begin
          cmd.ld_x = 1'b1;
          state_d  = S_X_RD;
        end
      end
      S_X_RD: begin
        cmd.rd_bit = 1'b1;
        state_d    = S_X_EV;
      end
      S_X_EV: begin
        cmd.x_step = 1'b1;
        if (sts_i.x_last) begin
          fin      = 1'b1;
          fin_code = fskscs_pkg::ST_OK;
        end else begin
          cmd.inc_idx = 1'b1;
          state_d     = S_X_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (fin) begin
      valid_d    = 1'b1;
      status_d   = fin_code;
      cmd.fin    = 1'b1;
      cmd.fin_ok = (fin_code == fskscs_pkg::ST_OK);
      state_d    = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= 1'b0;
      status_q <= fskscs_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      status_q <= status_d;
    end
  end

  assign cmd_o    = cmd;
  assign busy     = (state_q != S_IDLE);
  assign valid_o  = valid_q;
  assign status_o = status_q;

  `FSKSCS_ASSERT_CLK(a_valid_one_cycle, valid_q |=> !valid_q, "result strobe longer than one cycle")
  `FSKSCS_ASSERT_CLK(a_valid_idle, valid_q |-> state_q == S_IDLE, "result shown while busy")
  `FSKSCS_ASSERT_CLK(a_last_to_check, (state_q == S_IDLE && start && last_sample_i) |=> state_q == S_CHECK, "last sample did not start frame check")
  `FSKSCS_ASSERT_CLK(a_ok_after_pack, (valid_q && status_q == fskscs_pkg::ST_OK) |-> $past(state_q == S_X_EV), "ok status without packing")

endmodule
`default_nettype wire

@@ sv/fskscs_dp.sv @@
// datapath with sample and bit stores, reference bounds, sync search and packing
`default_nettype none
module fskscs_dp #(
  parameter int unsigned MAX_SAMPLES = fskscs_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire fskscs_pkg::cfg_t               cfg_i,
  input  wire fskscs_pkg::cmd_t               cmd_i,
  input  wire logic [fskscs_pkg::SIZE_W-1:0]  pulse_size_i,
  output fskscs_pkg::sts_t                    sts_o,
  output logic [fskscs_pkg::WORD_W-1:0]       data_word_o,
  output logic [fskscs_pkg::OFF_W-1:0]        sync_offset_o
);

  localparam int unsigned IW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned XW = ((CW > fskscs_pkg::LEN_W) ? CW : fskscs_pkg::LEN_W) + 1;
  localparam int unsigned SW = fskscs_pkg::SIZE_W;
  localparam int unsigned HW = fskscs_pkg::HI_W;
  localparam int unsigned WW = fskscs_pkg::WORD_W;

  logic [SW-1:0]  smp_mem [MAX_SAMPLES];
  logic           bit_mem [MAX_SAMPLES];

  logic [CW-1:0]  count_q;
  logic           ovf_q;
  logic [IW-1:0]  idx_q;
  logic [SW-1:0]  smp_q;
  logic           bit_q;
  logic [SW-1:0]  v0_q;
  logic [SW-1:0]  v1_q;
  logic [SW-1:0]  lo0_q;
  logic [SW-1:0]  lo1_q;
  logic [HW-1:0]  hi0_q;
  logic [HW-1:0]  hi1_q;
  logic           have1_q;
  logic           found_q;
  logic [IW-1:0]  start_q;
  logic [WW-1:0]  win_q;
  logic [WW-1:0]  win_d;
  logic [WW-1:0]  word_q;
  logic [WW-1:0]  word_d;
  logic [fskscs_pkg::XCNT_W-1:0] xcnt_q;
  logic [WW-1:0]  out_word_q;
  logic [fskscs_pkg::OFF_W-1:0] out_off_q;

  logic                          tol_done;
  logic [fskscs_pkg::DEV_W-1:0]  dev;

  logic           room;
  logic [XW-1:0]  count_x;
  logic [XW-1:0]  idx_x;
  logic [XW-1:0]  start_x;
  logic [XW-1:0]  db_x;
  logic [XW-1:0]  len_x;
  logic [XW-1:0]  expect_x;
  logic [XW-1:0]  idx_next_x;
  logic [SW-1:0]  lo_new;
  logic [HW-1:0]  hi_new;
  logic           near0;
  logic           near1;
  logic           sel1;
  logic [SW-1:0]  zlo;
  logic [HW-1:0]  zhi;
  logic           bit_d;
  logic [WW-1:0]  mask;
  logic           hit;
  logic [IW-1:0]  start_new;

  fskscs_tol u_tol (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.tol_go),
    .size_i (smp_q),
    .tol_i  (cfg_i.tolerance_percent),
    .done_o (tol_done),
    .dev_o  (dev)
  );

  assign room       = (count_q < CW'(MAX_SAMPLES));
  assign count_x    = XW'(count_q);
  assign idx_x      = XW'(idx_q);
  assign start_x    = XW'(start_q);
  assign db_x       = XW'(cfg_i.data_bits);
  assign len_x      = XW'(cfg_i.sync_length);
  assign expect_x   = cfg_i.repeat_twice ? (db_x << 1) : db_x;
  assign idx_next_x = idx_x + XW'(1);

  assign lo_new = ({1'b0, smp_q} >= dev) ? SW'({1'b0, smp_q} - dev) : '0;
  assign hi_new = HW'(smp_q) + HW'(dev);

  assign near0 = (smp_q >= lo0_q) && (HW'(smp_q) <= hi0_q);
  assign near1 = (smp_q >= lo1_q) && (HW'(smp_q) <= hi1_q);

  assign sel1  = have1_q && ((v1_q < v0_q) ^ (cfg_i.t0_above_t1 ^ cfg_i.invert));
  assign zlo   = sel1 ? lo1_q : lo0_q;
  assign zhi   = sel1 ? hi1_q : hi0_q;
  assign bit_d = !((smp_q >= zlo) && (HW'(smp_q) <= zhi));

  // newest bit at bit 0, window bit p holds sample idx - p
  assign win_d     = {win_q[WW-2:0], bit_d};
  assign mask      = ~({WW{1'b1}} << cfg_i.sync_length);
  assign hit       = (cfg_i.sync_length != '0) && (idx_next_x >= len_x) &&
                     (((win_d ^ cfg_i.sync_pattern) & mask) == '0);
  assign start_new = IW'(idx_next_x - len_x);

  assign word_d = cmd_i.x_step ? {word_q[WW-2:0], bit_q} : word_q;

  assign sts_o.cfg_err  = (cfg_i.data_bits == '0) ||
                          (cfg_i.data_bits > fskscs_pkg::MAX_DATA_BITS) ||
                          (cfg_i.sync_length > fskscs_pkg::MAX_SYNC_LEN) ||
                          ovf_q || (count_x != expect_x) || (count_q == '0);
  assign sts_o.idx_last = (idx_next_x == count_x);
  assign sts_o.near0    = near0;
  assign sts_o.near1    = near1;
  assign sts_o.have1    = have1_q;
  assign sts_o.tol_done = tol_done;
  assign sts_o.found    = found_q;
  assign sts_o.sync_on  = (cfg_i.sync_length != '0);
  assign sts_o.win_err  = ((start_x + db_x) > count_x);
  assign sts_o.x_last   = ({1'b0, xcnt_q} == (cfg_i.data_bits - fskscs_pkg::LEN_W'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      have1_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.fin) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.load) begin
        if (room) begin
          count_q <= count_q + CW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.clr_frame) begin
        have1_q <= 1'b0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.cap_b1) begin
          have1_q <= 1'b1;
        end
        if (cmd_i.cls_step && hit) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      smp_mem[count_q[IW-1:0]] <= pulse_size_i;
    end
    if (cmd_i.rd_smp) begin
      smp_q <= smp_mem[idx_q];
    end
    if (cmd_i.cls_step) begin
      bit_mem[idx_q] <= bit_d;
    end
    if (cmd_i.rd_bit) begin
      bit_q <= bit_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_idx) begin
      idx_q <= '0;
    end else if (cmd_i.ld_x) begin
      idx_q <= start_q;
    end else if (cmd_i.inc_idx) begin
      idx_q <= idx_q + IW'(1);
    end
    if (cmd_i.clr_frame) begin
      start_q <= '0;
    end else if (cmd_i.cls_step && !found_q && hit) begin
      start_q <= start_new;
    end
    if (cmd_i.cap_b0) begin
      v0_q  <= smp_q;
      lo0_q <= lo_new;
      hi0_q <= hi_new;
    end
    if (cmd_i.cap_b1) begin
      v1_q  <= smp_q;
      lo1_q <= lo_new;
      hi1_q <= hi_new;
    end
    if (cmd_i.cls_step) begin
      win_q <= win_d;
    end
    if (cmd_i.ld_x) begin
      word_q <= '0;
      xcnt_q <= '0;
    end else if (cmd_i.x_step) begin
      word_q <= word_d;
      xcnt_q <= xcnt_q + fskscs_pkg::XCNT_W'(1);
    end
    if (cmd_i.fin) begin
      out_word_q <= cmd_i.fin_ok ? word_d : '0;
      out_off_q  <= cmd_i.fin_ok ? start_x[fskscs_pkg::OFF_W-1:0] : '0;
    end
  end

  assign data_word_o   = out_word_q;
  assign sync_offset_o = out_off_q;

endmodule
`default_nettype wire

@@ sv/fsk_symbol_classify_and_sync_top.sv @@
// top level of the fsk symbol classify and sync block with its register file
//
// usage:
//   samples: drive pulse_size_i and last_sample_i with start high; a sample
//   transaction completes at a clock edge with start high and busy low.
//   samples load one per cycle while busy is low.
//   the sample with last_sample_i high starts frame processing and raises
//   busy until the result is out.
//   result: valid_o is high for exactly one cycle with data_word_o,
//   sync_offset_o and status_o; the receiver cannot stall it.
//   processing: for a frame with two sizes the block makes two sample
//   memory passes (reference sizes, then classification) and one bit
//   memory pass over the data bits, plus a deviation unit run for each
//   size, only one run when all samples share one size; count errors report
//   at the frame check or after classifying, a bad size or missing sync
//   ends earlier. busy falls as the result appears, so the next frame can
//   load in the same cycle.
//   configuration: cfg_we_i, cfg_idx_i, cfg_wdata_i write one register per
//   cycle; the user must write only while the block is idle; not enforced.
//   reset: clears registers to defaults and empties the frame; no sweep.
`default_nettype none
module fsk_symbol_classify_and_sync_top #(
  parameter int unsigned MAX_SAMPLES = fskscs_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [fskscs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [fskscs_pkg::WORD_W-1:0]      cfg_wdata_i,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [fskscs_pkg::SIZE_W-1:0]      pulse_size_i,
  input  wire logic                               last_sample_i,
  output logic                                    valid_o,
  output logic [fskscs_pkg::WORD_W-1:0]           data_word_o,
  output logic [fskscs_pkg::OFF_W-1:0]            sync_offset_o,
  output logic [fskscs_pkg::STATUS_W-1:0]         status_o
);

  fskscs_pkg::cfg_t cfg_q;
  fskscs_pkg::cmd_t cmd;
  fskscs_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_pattern      <= fskscs_pkg::RST_SYNC_PATTERN;
      cfg_q.sync_length       <= fskscs_pkg::RST_SYNC_LENGTH;
      cfg_q.data_bits         <= fskscs_pkg::RST_DATA_BITS;
      cfg_q.repeat_twice      <= fskscs_pkg::RST_REPEAT_TWICE;
      cfg_q.invert            <= fskscs_pkg::RST_INVERT;
      cfg_q.t0_above_t1       <= fskscs_pkg::RST_T0_ABOVE_T1;
      cfg_q.tolerance_percent <= fskscs_pkg::RST_TOLERANCE;
    end else if (cfg_we_i) begin
      case (fskscs_pkg::cfg_idx_e'(cfg_idx_i))
        fskscs_pkg::CFG_SYNC_PATTERN: begin
          cfg_q.sync_pattern <= cfg_wdata_i;
        end
        fskscs_pkg::CFG_SYNC_LENGTH: begin
          cfg_q.sync_length <= cfg_wdata_i[fskscs_pkg::LEN_W-1:0];
        end
        fskscs_pkg::CFG_DATA_BITS: begin
          cfg_q.data_bits <= cfg_wdata_i[fskscs_pkg::LEN_W-1:0];
        end
        fskscs_pkg::CFG_REPEAT_TWICE: begin
          cfg_q.repeat_twice <= cfg_wdata_i[0];
        end
        fskscs_pkg::CFG_INVERT: begin
          cfg_q.invert <= cfg_wdata_i[0];
        end
        fskscs_pkg::CFG_T0_ABOVE_T1: begin
          cfg_q.t0_above_t1 <= cfg_wdata_i[0];
        end
        fskscs_pkg::CFG_TOLERANCE: begin
          cfg_q.tolerance_percent <= cfg_wdata_i[fskscs_pkg::TOL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  fskscs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .last_sample_i (last_sample_i),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .busy          (busy),
    .valid_o       (valid_o),
    .status_o      (status_o)
  );

  fskscs_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .pulse_size_i  (pulse_size_i),
    .sts_o         (sts),
    .data_word_o   (data_word_o),
    .sync_offset_o (sync_offset_o)
  );

endmodule
`default_nettype wire
